FILE: src/multi_button_debouncer_macros.svh
// Assertion macros used by the checker file.
`ifndef MULTI_BUTTON_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: src/mbd_pkg.sv
`timescale 1ns / 1ps
package mbd_pkg;

	localparam int LANE_LIMIT = 4;
	localparam int PIN_W      = 4;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUTTON_COUNT = 3'd0,
		REG_ACTIVE_HIGH  = 3'd1,
		REG_TICK_PERIOD  = 3'd2,
		REG_DEBOUNCE_0   = 3'd3,
		REG_DEBOUNCE_1   = 3'd4,
		REG_DEBOUNCE_2   = 3'd5,
		REG_DEBOUNCE_3   = 3'd6
	} cfg_reg_e;

	typedef enum logic [1:0] {
		TH_IDLE,
		TH_LOAD,
		TH_DIV
	} th_state_t;

	typedef struct packed {
		logic en;
		logic active;
		logic level;
		logic polarity;
	} lane_ctl_t;

	typedef struct packed {
		logic stable;
		logic flip;
	} lane_res_t;

	typedef struct packed {
		logic busy;
		logic load;
		logic step;
	} th_ctl_t;

endpackage

FILE: src/mbd_if.sv
`timescale 1ns / 1ps
interface mbd_sample_if import mbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIN_W-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

interface mbd_result_if import mbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIN_W-1:0] pressed_mask;
	logic [PIN_W-1:0] changed;

	modport source (output valid, output pressed_mask, output changed, input ready);
	modport sink (input valid, input pressed_mask, input changed, output ready);
endinterface

interface mbd_cfg_if import mbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/mbd_lane.sv
`timescale 1ns / 1ps
module mbd_lane import mbd_pkg::*; #(
	parameter int TIME_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lane_ctl_t             ctl,
	input  logic [TIME_WIDTH-1:0] threshold,
	output lane_res_t             res
);

	logic                  stable_q;
	logic                  stable_d;
	logic [TIME_WIDTH-1:0] count_q;
	logic [TIME_WIDTH-1:0] count_d;
	logic [TIME_WIDTH-1:0] count_inc;
	logic                  pressed;
	logic                  flip;

	assign pressed   = (ctl.level == ctl.polarity);
	assign count_inc = count_q + TIME_WIDTH'(1);

	always_comb begin
		stable_d = stable_q;
		count_d  = count_q;
		flip     = 1'b0;
		if (!ctl.active) begin
			// A lane outside the configured count rests released.
			stable_d = 1'b0;
			count_d  = '0;
		end else if (pressed == stable_q) begin
			count_d = '0;
		end else if (count_inc >= threshold) begin
			stable_d = ~stable_q;
			count_d  = '0;
			flip     = 1'b1;
		end else begin
			count_d = count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			count_q  <= '0;
		end else if (ctl.en) begin
			stable_q <= stable_d;
			count_q  <= count_d;
		end
	end

	assign res.stable = stable_d;
	assign res.flip   = flip;

endmodule

FILE: src/mbd_thresh.sv
`timescale 1ns / 1ps
module mbd_thresh import mbd_pkg::*; #(
	parameter int LANES      = 4,
	parameter int TIME_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CFG_DATA_W-1:0] tick_period,
	input  logic [CFG_DATA_W-1:0] debounce_time [LANES],
	output logic [TIME_WIDTH-1:0] threshold [LANES],
	output logic                  busy
);

	localparam int SW = $clog2(TIME_WIDTH);
	localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;

	th_state_t             state_q;
	th_state_t             state_d;
	th_ctl_t               ctl;
	logic [IW-1:0]         idx_q;
	logic [SW-1:0]         step_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [TIME_WIDTH-1:0] quo_q;
	logic [TIME_WIDTH-1:0] dvs_q;
	logic [TIME_WIDTH-1:0] thr_q [LANES];

	logic [TIME_WIDTH-1:0] d_raw;
	logic [TIME_WIDTH-1:0] d_eff;
	logic [TIME_WIDTH-1:0] t_raw;
	logic [TIME_WIDTH-1:0] t_eff;
	logic [TIME_WIDTH:0]   shifted;
	logic [TIME_WIDTH+1:0] diff;
	logic                  fits;
	logic [TIME_WIDTH-1:0] rem_d;
	logic [TIME_WIDTH-1:0] quo_d;
	logic                  step_last;
	logic                  lane_last;

	// Zero operands count as one.
	assign d_raw = TIME_WIDTH'(debounce_time[idx_q]);
	assign d_eff = (d_raw == '0) ? TIME_WIDTH'(1) : d_raw;
	assign t_raw = TIME_WIDTH'(tick_period);
	assign t_eff = (t_raw == '0) ? TIME_WIDTH'(1) : t_raw;

	// One quotient bit per cycle, restoring division.
	assign shifted = {rem_q, quo_q[TIME_WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[TIME_WIDTH+1];
	assign rem_d   = fits ? diff[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
	assign quo_d   = {quo_q[TIME_WIDTH-2:0], fits};

	assign step_last = (step_q == SW'(TIME_WIDTH - 1));
	assign lane_last = (idx_q == IW'(LANES - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TH_IDLE: if (start) state_d = TH_LOAD;
			TH_LOAD: state_d = TH_DIV;
			TH_DIV: begin
				if (step_last) begin
					state_d = lane_last ? TH_IDLE : TH_LOAD;
				end
			end
			default: state_d = TH_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			TH_IDLE: ctl = '0;
			TH_LOAD: begin
				ctl.busy = 1'b1;
				ctl.load = 1'b1;
			end
			TH_DIV: begin
				ctl.busy = 1'b1;
				ctl.step = 1'b1;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TH_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == TH_IDLE && start) begin
				idx_q <= '0;
			end else if (ctl.step && step_last && !lane_last) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.load) begin
				step_q <= '0;
			end else if (ctl.step) begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= d_eff;
			dvs_q <= t_eff;
		end else if (ctl.step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				thr_q[i] <= TIME_WIDTH'(1);
			end
		end else if (ctl.step && step_last) begin
			// A quotient of zero is raised to one.
			thr_q[idx_q] <= (quo_d == '0) ? TIME_WIDTH'(1) : quo_d;
		end
	end

	assign threshold = thr_q;
	assign busy      = ctl.busy;

endmodule

FILE: src/multi_button_debouncer.sv
`timescale 1ns / 1ps
// Debounces up to four buttons, one lane per button, min(NUM_BUTTONS, 4) lanes in all.
// Each sample item carries the raw pin levels of one tick and yields exactly one result
// item with the debounced pressed mask and the mask of lanes that flipped on that tick.
// One item is taken per clock cycle while the divider is idle; its result sits in the
// output register in the next cycle, and a new item is taken only while that register is
// empty or being emptied. The flip thresholds are debounce_time / tick_period, worked
// out by one shared bit-serial divider after a write to the tick period or any debounce
// time; during this update neither samples nor configuration writes are accepted.
// Register indexes: 0 button count, 1 active-high mask, 2 tick period, 3 to 6 debounce
// time of buttons 0 to 3; other indexes are ignored.
module multi_button_debouncer import mbd_pkg::*; #(
	parameter int NUM_BUTTONS = 4,
	parameter int TIME_WIDTH  = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	mbd_sample_if.sink   samples,
	mbd_result_if.source results,
	mbd_cfg_if.sink      cfg
);

	localparam int LANES = (NUM_BUTTONS < LANE_LIMIT) ? NUM_BUTTONS : LANE_LIMIT;

	logic [COUNT_W-1:0]    button_count_q;
	logic [PIN_W-1:0]      polarity_q;
	logic [CFG_DATA_W-1:0] tick_q;
	logic [CFG_DATA_W-1:0] debounce_q [LANES];
	logic [TIME_WIDTH-1:0] threshold [LANES];

	logic            th_busy;
	logic            cfg_wr;
	logic            timing_wr;
	logic            sample_acc;
	logic            res_valid_q;
	logic [PIN_W-1:0] stable_q;
	logic [PIN_W-1:0] changed_q;
	logic [PIN_W-1:0] stable_mask;
	logic [PIN_W-1:0] changed_mask;
	lane_res_t       lane_res [LANES];

	assign cfg.ready  = ~th_busy;
	assign cfg_wr     = cfg.valid & cfg.ready;
	assign timing_wr  = cfg_wr & ((cfg.index == REG_TICK_PERIOD) ||
		(cfg.index == REG_DEBOUNCE_0) || (cfg.index == REG_DEBOUNCE_1) ||
		(cfg.index == REG_DEBOUNCE_2) || (cfg.index == REG_DEBOUNCE_3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_count_q <= '0;
			polarity_q     <= '0;
			tick_q         <= CFG_DATA_W'(1);
			for (int i = 0; i < LANES; i++) begin
				debounce_q[i] <= CFG_DATA_W'(1);
			end
		end else if (cfg_wr) begin
			if (cfg.index == REG_BUTTON_COUNT) begin
				button_count_q <= cfg.data[COUNT_W-1:0];
			end
			if (cfg.index == REG_ACTIVE_HIGH) begin
				polarity_q <= cfg.data[PIN_W-1:0];
			end
			if (cfg.index == REG_TICK_PERIOD) begin
				tick_q <= cfg.data;
			end
			for (int i = 0; i < LANES; i++) begin
				if (cfg.index == CFG_IDX_W'(int'(REG_DEBOUNCE_0) + i)) begin
					debounce_q[i] <= cfg.data;
				end
			end
		end
	end

	mbd_thresh #(
		.LANES      (LANES),
		.TIME_WIDTH (TIME_WIDTH)
	) u_thresh (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (timing_wr),
		.tick_period   (tick_q),
		.debounce_time (debounce_q),
		.threshold     (threshold),
		.busy          (th_busy)
	);

	assign samples.ready = ~th_busy & (~res_valid_q | results.ready);
	assign sample_acc    = samples.valid & samples.ready;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lane_ctl_t ctl;

		assign ctl.en       = sample_acc;
		assign ctl.active   = (button_count_q > COUNT_W'(g));
		assign ctl.level    = samples.pin_levels[g];
		assign ctl.polarity = polarity_q[g];

		mbd_lane #(
			.TIME_WIDTH (TIME_WIDTH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.threshold (threshold[g]),
			.res       (lane_res[g])
		);
	end

	// Merge the lane results into the two result masks.
	always_comb begin
		stable_mask  = '0;
		changed_mask = '0;
		for (int i = 0; i < LANES; i++) begin
			stable_mask[i]  = lane_res[i].stable;
			changed_mask[i] = lane_res[i].flip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sample_acc) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			stable_q  <= stable_mask;
			changed_q <= changed_mask;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.pressed_mask = stable_q;
	assign results.changed      = changed_q;

endmodule

FILE: src/mbd_checker.sv
`timescale 1ns / 1ps
`include "multi_button_debouncer_macros.svh"
module mbd_checker import mbd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_valid,
	input logic                 s_ready,
	input logic                 r_valid,
	input logic                 r_ready,
	input logic [PIN_W-1:0]     r_stable,
	input logic [PIN_W-1:0]     r_changed,
	input logic                 c_valid,
	input logic                 c_ready,
	input logic [CFG_IDX_W-1:0] c_index
);

	logic timing_wr;

	assign timing_wr = c_valid && c_ready && ((c_index == REG_TICK_PERIOD) ||
		(c_index == REG_DEBOUNCE_0) || (c_index == REG_DEBOUNCE_1) ||
		(c_index == REG_DEBOUNCE_2) || (c_index == REG_DEBOUNCE_3));

	// A result that is held back keeps its value.
	`MBD_ASSERT_NEXT(a_result_hold, clk, arst_n, r_valid && !r_ready, r_valid && $stable(r_stable) && $stable(r_changed))

	// Every accepted item shows its result in the next cycle.
	`MBD_ASSERT_NEXT(a_result_follows, clk, arst_n, s_valid && s_ready, r_valid)

	// A full, stalled output register blocks new items.
	`MBD_ASSERT_SAME(a_no_overrun, clk, arst_n, r_valid && !r_ready, !s_ready)

	// A timing write starts the threshold update, which holds off both inputs.
	`MBD_ASSERT_NEXT(a_recompute_block, clk, arst_n, timing_wr, !s_ready && !c_ready)

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_valid   (samples.valid),
	.s_ready   (samples.ready),
	.r_valid   (results.valid),
	.r_ready   (results.ready),
	.r_stable  (results.pressed_mask),
	.r_changed (results.changed),
	.c_valid   (cfg.valid),
	.c_ready   (cfg.ready),
	.c_index   (cfg.index)
);
